>>> design/gbn_pkg.sv
// Shared types and constants for the go-back-N sender window.
// No dependencies; every other design file imports this package.
package gbn_pkg;

    localparam int SEQ_W       = 16;
    localparam int WINDOW_DEF  = 16;
    localparam int WINDOW_MAX  = 64;
    localparam int OUTS_W      = $clog2(WINDOW_MAX + 1);
    localparam int QDEPTH_DEF  = 4;
    localparam int OUT_OUTS_W  = 5;

    localparam logic [SEQ_W-1:0] TOTAL_RST   = 16'd1;
    localparam logic [SEQ_W-1:0] FIRST_RST   = 16'd2;
    localparam logic [SEQ_W-1:0] TIMEOUT_RST = 16'd1000;

    localparam logic [2:0] REPEAT_FAST = 3'd3;
    localparam logic [2:0] REPEAT_MAX  = 3'd7;

    // configuration register indexes
    localparam logic [1:0] CFG_TOTAL   = 2'd0;
    localparam logic [1:0] CFG_FIRST   = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT = 2'd2;

    typedef enum logic [1:0] {
        CMD_OFFER = 2'd0,
        CMD_ACK   = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_GRANT  = 2'd0,
        KIND_REFUSE = 2'd1,
        KIND_RETX   = 2'd2,
        KIND_STATUS = 2'd3
    } kind_t;

    // One classified item: an optional head beat, then an optional retransmit run
    // of 'outs' beats starting at 'seq'.
    typedef struct packed {
        logic              has_head;
        kind_t             head_kind;
        logic [SEQ_W-1:0]  seq;
        logic              do_run;
        logic              done;
        logic [OUTS_W-1:0] outs;
    } job_t;

endpackage

>>> design/go_back_n_sender_window_unit.sv
// Go-back-N sender window. An item is classified in the cycle it is accepted; it is
// pushed into the job queue, loaded by the beat generator and then shown on the result
// port. A one-beat item occupies the beat generator for a job load and then a beat; a
// retransmit run adds one beat per sequence number. Items are taken while the job
// queue (QDEPTH entries) has room. Reset restores the register defaults and the
// initial window at sequence number 2, and empties the queue and result register.
module go_back_n_sender_window_unit #(
    parameter int WINDOW = gbn_pkg::WINDOW_DEF,
    parameter int QDEPTH = gbn_pkg::QDEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr,
    input  logic [1:0]                     cfg_idx,
    input  logic [gbn_pkg::SEQ_W-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     cmd,
    input  logic [gbn_pkg::SEQ_W-1:0]      ack_num,
    input  logic                           ack_ok,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     kind,
    output logic [gbn_pkg::SEQ_W-1:0]      seq,
    output logic                           last,
    output logic                           done_res,
    output logic [gbn_pkg::OUT_OUTS_W-1:0] outstanding
);
    import gbn_pkg::*;

    logic q_push, q_full, q_pop, q_empty;
    job_t push_job, pop_job;

    gbn_front #(
        .WINDOW (WINDOW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_wr),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .ack_num  (ack_num),
        .ack_ok   (ack_ok),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    gbn_job_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .job_in  (push_job),
        .full    (q_full),
        .pop     (q_pop),
        .job_out (pop_job),
        .empty   (q_empty)
    );

    gbn_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_job       (pop_job),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .seq         (seq),
        .last        (last),
        .done_res    (done_res),
        .outstanding (outstanding)
    );

endmodule

>>> design/gbn_front.sv
// Front end: configuration registers, window state and classification of items.
// Depends on gbn_pkg; pushes one job_t per item that produces beats.
module gbn_front #(
    parameter int WINDOW = gbn_pkg::WINDOW_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr,
    input  logic [1:0]                 cfg_idx,
    input  logic [gbn_pkg::SEQ_W-1:0]  cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 cmd,
    input  logic [gbn_pkg::SEQ_W-1:0]  ack_num,
    input  logic                       ack_ok,
    input  logic                       q_full,
    output logic                       q_push,
    output gbn_pkg::job_t              q_job
);
    import gbn_pkg::*;

    logic [SEQ_W-1:0] total_reg, first_reg, timeout_reg;
    logic [SEQ_W-1:0] base_reg, base_next;
    logic [SEQ_W-1:0] next_seq_reg, next_seq_next;
    logic [SEQ_W-1:0] idle_reg, idle_next;
    logic [SEQ_W-1:0] rval_reg, rval_next;
    logic             rvalid_reg, rvalid_next;
    logic [2:0]       rcnt_reg, rcnt_next;
    logic             done_reg, done_next;

    logic             accept;
    logic [SEQ_W-1:0] outs_old;
    logic             grant;
    logic             ack_good;
    logic             ack_moved;
    logic [SEQ_W-1:0] outs_ack;
    logic [SEQ_W-1:0] idle_inc;

    assign accept   = in_valid && !q_full;
    assign in_stall = q_full;
    assign outs_old = next_seq_reg - base_reg;
    assign grant    = !done_reg && (outs_old < SEQ_W'(WINDOW))
                      && ((next_seq_reg - first_reg) < total_reg);
    assign ack_good = ack_ok && !done_reg;
    assign ack_moved = (ack_num - base_reg) < outs_old;
    // outstanding after a good ACK: base moves to ack+1 when the ACK is in range
    assign outs_ack = (ack_good && ack_moved) ? (next_seq_reg - ack_num - 16'd1) : outs_old;
    assign idle_inc = (idle_reg == '1) ? idle_reg : idle_reg + 16'd1;

    always_comb
    begin
        base_next     = base_reg;
        next_seq_next = next_seq_reg;
        idle_next     = idle_reg;
        rval_next     = rval_reg;
        rvalid_next   = rvalid_reg;
        rcnt_next     = rcnt_reg;
        done_next     = done_reg;
        q_push        = 1'b0;
        q_job         = '0;
        if (accept)
        begin
            case (cmd_t'(cmd))
                CMD_OFFER:
                begin
                    if (grant)
                    begin
                        if (outs_old == '0)
                        begin
                            idle_next = '0;
                        end
                        next_seq_next = next_seq_reg + 16'd1;
                    end
                    q_push          = 1'b1;
                    q_job.has_head  = 1'b1;
                    q_job.head_kind = grant ? KIND_GRANT : KIND_REFUSE;
                    q_job.seq       = next_seq_reg;
                    q_job.do_run    = 1'b0;
                    q_job.done      = done_reg;
                    q_job.outs      = OUTS_W'(grant ? outs_old + 16'd1 : outs_old);
                end
                CMD_ACK:
                begin
                    q_job.do_run = 1'b0;
                    if (ack_good)
                    begin
                        if (ack_moved)
                        begin
                            base_next = ack_num + 16'd1;
                        end
                        if (outs_ack != '0)
                        begin
                            idle_next = '0;
                        end
                        if (ack_num == total_reg + 16'd1)
                        begin
                            done_next = 1'b1;
                        end
                        else if (!rvalid_reg || rval_reg != ack_num)
                        begin
                            rcnt_next   = '0;
                            rval_next   = ack_num;
                            rvalid_next = 1'b1;
                        end
                        else if (rcnt_reg < REPEAT_MAX)
                        begin
                            rcnt_next = rcnt_reg + 3'd1;
                            // third repeat: retransmit the whole window
                            if (rcnt_next == REPEAT_FAST)
                            begin
                                q_job.do_run = 1'b1;
                                idle_next    = '0;
                            end
                        end
                    end
                    q_push          = 1'b1;
                    q_job.has_head  = 1'b1;
                    q_job.head_kind = KIND_STATUS;
                    q_job.seq       = base_next;
                    q_job.done      = done_next;
                    q_job.outs      = OUTS_W'(outs_ack);
                end
                CMD_TICK:
                begin
                    if (!done_reg)
                    begin
                        if (idle_inc >= timeout_reg)
                        begin
                            idle_next = '0;
                            // an empty window gives no beats
                            q_push          = (outs_old != '0);
                            q_job.has_head  = 1'b0;
                            q_job.head_kind = KIND_RETX;
                            q_job.seq       = base_reg;
                            q_job.do_run    = 1'b1;
                            q_job.done      = done_reg;
                            q_job.outs      = OUTS_W'(outs_old);
                        end
                        else
                        begin
                            idle_next = idle_inc;
                        end
                    end
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg    <= TOTAL_RST;
            first_reg    <= FIRST_RST;
            timeout_reg  <= TIMEOUT_RST;
            base_reg     <= FIRST_RST;
            next_seq_reg <= FIRST_RST;
            idle_reg     <= '0;
            rval_reg     <= '0;
            rvalid_reg   <= 1'b0;
            rcnt_reg     <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            base_reg     <= base_next;
            next_seq_reg <= next_seq_next;
            idle_reg     <= idle_next;
            rval_reg     <= rval_next;
            rvalid_reg   <= rvalid_next;
            rcnt_reg     <= rcnt_next;
            done_reg     <= done_next;
            if (cfg_wr)
            begin
                case (cfg_idx)
                    CFG_TOTAL:   total_reg   <= cfg_data;
                    CFG_FIRST:   first_reg   <= cfg_data;
                    CFG_TIMEOUT: timeout_reg <= cfg_data;
                    default:     total_reg   <= total_reg;
                endcase
            end
        end
    end

endmodule

>>> design/gbn_job_fifo.sv
// Short queue of classified jobs between the front end and the beat generator.
// Depends on gbn_pkg for job_t. DEPTH of 2 or more.
module gbn_job_fifo #(
    parameter int DEPTH = gbn_pkg::QDEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gbn_pkg::job_t job_in,
    output logic          full,
    input  logic          pop,
    output gbn_pkg::job_t job_out,
    output logic          empty
);
    import gbn_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign job_out = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= job_in;
        end
    end

endmodule

>>> design/gbn_back.sv
// Beat generator: expands one job into a head beat, a retransmit run or both.
// Depends on gbn_pkg; drives the registered result channel.
module gbn_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  gbn_pkg::job_t               q_job,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  kind,
    output logic [gbn_pkg::SEQ_W-1:0]   seq,
    output logic                        last,
    output logic                        done_res,
    output logic [gbn_pkg::OUT_OUTS_W-1:0] outstanding
);
    import gbn_pkg::*;

    logic              busy_reg, busy_next;
    logic              head_reg, head_next;
    kind_t             head_kind_reg, head_kind_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic [OUTS_W-1:0] left_reg, left_next;
    logic              done_reg, done_next;
    logic [OUTS_W-1:0] outs_reg, outs_next;

    logic              out_valid_reg, out_valid_next;
    kind_t             kind_reg;
    logic [SEQ_W-1:0]  oseq_reg;
    logic              last_reg;
    logic              odone_reg;
    logic [OUTS_W-1:0] oouts_reg;

    logic              take;
    logic              emit;
    kind_t             beat_kind;
    logic              beat_last;

    assign take  = !out_valid_reg || !out_stall;
    assign emit  = busy_reg && take;
    assign q_pop = !busy_reg && !q_empty;

    assign beat_kind = head_reg ? head_kind_reg : KIND_RETX;
    assign beat_last = head_reg ? (left_reg == '0) : (left_reg == OUTS_W'(1));

    always_comb
    begin
        busy_next      = busy_reg;
        head_next      = head_reg;
        head_kind_next = head_kind_reg;
        seq_next       = seq_reg;
        left_next      = left_reg;
        done_next      = done_reg;
        outs_next      = outs_reg;
        if (q_pop)
        begin
            busy_next      = 1'b1;
            head_next      = q_job.has_head;
            head_kind_next = q_job.head_kind;
            seq_next       = q_job.seq;
            left_next      = q_job.do_run ? q_job.outs : '0;
            done_next      = q_job.done;
            outs_next      = q_job.outs;
        end
        else if (emit)
        begin
            if (head_reg)
            begin
                // the run starts at the status base, so hold seq
                head_next = 1'b0;
            end
            else
            begin
                seq_next  = seq_reg + 16'd1;
                left_next = left_reg - OUTS_W'(1);
            end
            if (beat_last)
            begin
                busy_next = 1'b0;
            end
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            head_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_kind_reg <= head_kind_next;
        seq_reg       <= seq_next;
        left_reg      <= left_next;
        done_reg      <= done_next;
        outs_reg      <= outs_next;
        if (emit)
        begin
            kind_reg  <= beat_kind;
            oseq_reg  <= seq_reg;
            last_reg  <= beat_last;
            odone_reg <= done_reg;
            oouts_reg <= outs_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign seq         = oseq_reg;
    assign last        = last_reg;
    assign done_res    = odone_reg;
    assign outstanding = OUT_OUTS_W'(oouts_reg);

endmodule

>>> design/gbn_checker.sv
// Port-level checks on the result channel of the sender window.
// Depends on gbn_pkg; bound to go_back_n_sender_window_unit below.
module gbn_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [1:0]                kind,
    input logic [gbn_pkg::SEQ_W-1:0] seq,
    input logic                      last,
    input logic                      done_res
);
    import gbn_pkg::*;

    // stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(seq) && $stable(kind) && $stable(last))
        else $error("result beat changed while stalled");

    // an offer always gives exactly one beat
    a_offer_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_GRANT || kind == KIND_REFUSE) |-> last)
        else $error("grant or refusal beat not marked last");

    // nothing is granted or resent once the transfer is complete
    a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_GRANT || kind == KIND_RETX) |-> !done_res)
        else $error("grant or retransmit after completion");

    // a run continues without gaps with consecutive sequence numbers
    a_run_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && kind == KIND_RETX && !last
        |=> out_valid && kind == KIND_RETX && seq == 16'($past(seq) + 16'd1))
        else $error("retransmit run broken");

    // a status beat that is not last is followed by a run from the window base
    a_status_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && kind == KIND_STATUS && !last
        |=> out_valid && kind == KIND_RETX && seq == $past(seq))
        else $error("fast retransmit does not start at window base");

endmodule

bind go_back_n_sender_window_unit gbn_checker u_gbn_checker (.*);
